### design/clipped_colormap_pixel_render_top_assert.svh
// Assertion macros for the colormap render block.
// Included by the top module, which checks its own logic; no other dependencies.
`ifndef CLIPPED_COLORMAP_PIXEL_RENDER_TOP_ASSERT_SVH
`define CLIPPED_COLORMAP_PIXEL_RENDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CMAP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CMAP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CMAP_ASSERT(lbl, prop, msg)
`define CMAP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/cmap_pkg.sv
// Shared constants, codes and pipeline types for the colormap render block.
// No dependencies.
package cmap_pkg;
   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LAST_W      = 12;
   localparam int DATA_W      = 32;
   localparam int COLOR_W     = 24;
   localparam int CSR_W       = 3;
   localparam int NUM_W       = DATA_W + LAST_W + 2;
   localparam int DEN_W       = DATA_W + 1;

   localparam logic [CSR_W-1:0] CSR_LOW  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_HIGH = 3'd1;
   localparam logic [CSR_W-1:0] CSR_LAST = 3'd2;
   localparam logic [CSR_W-1:0] CSR_NAN  = 3'd3;
   localparam logic [CSR_W-1:0] CSR_BG   = 3'd4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [1:0] SEL_BG  = 2'd0;
   localparam logic [1:0] SEL_NAN = 2'd1;
   localparam logic [1:0] SEL_TBL = 2'd2;

   typedef struct packed {
      logic              vld;
      logic              op;
      logic              wr_ok;
      logic [LAST_W-1:0] load_idx;
      logic [COLOR_W-1:0] load_rgb;
      logic [1:0]        sel;
      logic              use_div;
      logic [LAST_W-1:0] idx;
      logic [LAST_W-1:0] last;
   } ctl_type;

   typedef struct packed {
      logic [DEN_W-1:0]  r;
      logic [LAST_W-1:0] low;
      logic [LAST_W-1:0] q;
      logic [DEN_W-1:0]  den;
   } div_type;
endpackage

### design/cmap_front.sv
// Front end: input register, classify/clip, 32x12 multiply, numerator build.
// Depends on cmap_pkg.
module cmap_front import cmap_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     req_valid,
   input  logic                     req_opcode,
   input  logic [LAST_W-1:0]        req_entry_index,
   input  logic [7:0]               req_entry_red,
   input  logic [7:0]               req_entry_green,
   input  logic [7:0]               req_entry_blue,
   input  logic signed [DATA_W-1:0] req_pixel_value,
   input  logic                     req_pixel_invalid,
   input  logic                     req_in_bounds,
   input  logic signed [DATA_W-1:0] low_limit,
   input  logic signed [DATA_W-1:0] high_limit,
   input  logic [LAST_W-1:0]        last_index,
   output ctl_type                  ctl_out,
   output div_type                  div_out
);
   ctl_type c0_ff, c0_in, c1_ff, c1_in, c2_ff, c3_ff;
   logic signed [DATA_W-1:0] val0_ff;
   logic inv0_ff, inb0_ff;
   logic [DATA_W-1:0] off1_ff, off1_in, span1_ff, span1_in, span2_ff;
   logic [DATA_W+LAST_W-1:0] prod2_ff, prod2_in;
   logic [NUM_W-1:0] num3;
   div_type d3_ff, d3_in;
   logic [LAST_W-1:0] last_sat;
   logic signed [DATA_W:0] off_w, span_w;

   // stage 0: capture
   always_comb begin
      c0_in          = '0;
      c0_in.vld      = req_valid;
      c0_in.op       = req_opcode;
      c0_in.wr_ok    = (32'(req_entry_index) < TABLE_DEPTH);
      c0_in.load_idx = req_entry_index;
      c0_in.load_rgb = {req_entry_red, req_entry_green, req_entry_blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
      end else if (adv) begin
         c0_ff <= c0_in;
      end
      if (adv) begin
         val0_ff <= req_pixel_value;
         inv0_ff <= req_pixel_invalid;
         inb0_ff <= req_in_bounds;
      end
   end

   // stage 1: classify and clip
   always_comb begin
      last_sat = (32'(last_index) > TABLE_DEPTH - 1) ? LAST_W'(TABLE_DEPTH - 1) : last_index;
      off_w    = $signed({val0_ff[DATA_W-1], val0_ff}) - $signed({low_limit[DATA_W-1], low_limit});
      span_w   = $signed({high_limit[DATA_W-1], high_limit})
               - $signed({low_limit[DATA_W-1], low_limit});
      off1_in  = off_w[DATA_W-1:0];
      span1_in = span_w[DATA_W-1:0];
      c1_in         = c0_ff;
      c1_in.last    = last_sat;
      c1_in.use_div = 1'b0;
      c1_in.idx     = '0;
      if (!inb0_ff) begin
         c1_in.sel = SEL_BG;
      end else if (inv0_ff) begin
         c1_in.sel = SEL_NAN;
      end else begin
         c1_in.sel = SEL_TBL;
      end
      if (val0_ff <= low_limit) begin
         c1_in.idx = '0;
      end else if (val0_ff >= high_limit) begin
         c1_in.idx = last_sat;
      end else begin
         c1_in.use_div = 1'b1;
      end
   end

   // stage 2: off * last
   assign prod2_in = (DATA_W+LAST_W)'(off1_ff) * (DATA_W+LAST_W)'(c1_ff.last);

   // stage 3: numerator 2*off*last + span, denominator 2*span
   always_comb begin
      num3     = {prod2_ff, 1'b0} + NUM_W'(span2_ff);
      d3_in.r   = num3[NUM_W-2:LAST_W];
      d3_in.low = num3[LAST_W-1:0];
      d3_in.q   = '0;
      d3_in.den = {span2_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else if (adv) begin
         c1_ff <= c1_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
      if (adv) begin
         off1_ff  <= off1_in;
         span1_ff <= span1_in;
         prod2_ff <= prod2_in;
         span2_ff <= span1_ff;
         d3_ff    <= d3_in;
      end
   end

   assign ctl_out = c3_ff;
   assign div_out = d3_ff;
endmodule

### design/cmap_div_stage.sv
// One restoring-division step: one quotient bit per stage.
// Depends on cmap_pkg.
module cmap_div_stage import cmap_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  ctl_type ctl_in,
   input  div_type div_in,
   output ctl_type ctl_out,
   output div_type div_out
);
   ctl_type c_ff;
   div_type d_ff, d_in;
   logic [DEN_W:0] t;
   logic ge;

   always_comb begin
      t  = {div_in.r, div_in.low[LAST_W-1]};
      ge = (t >= {1'b0, div_in.den});
      d_in     = div_in;
      d_in.r   = ge ? DEN_W'(t - {1'b0, div_in.den}) : t[DEN_W-1:0];
      d_in.low = {div_in.low[LAST_W-2:0], 1'b0};
      d_in.q   = {div_in.q[LAST_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
      end else if (adv) begin
         c_ff <= ctl_in;
      end
      if (adv) begin
         d_ff <= d_in;
      end
   end

   assign ctl_out = c_ff;
   assign div_out = d_ff;
endmodule

### design/cmap_table.sv
// Index select and color table: loads write, renders read, in item order.
// Depends on cmap_pkg.
module cmap_table import cmap_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  ctl_type            ctl_in,
   input  div_type            div_in,
   input  logic [COLOR_W-1:0] nan_color,
   input  logic [COLOR_W-1:0] background_color,
   output logic               out_valid,
   output logic [COLOR_W-1:0] out_rgb
);
   ctl_type c_ff;
   logic [LAST_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] addr;
   logic [COLOR_W-1:0] mem [TABLE_DEPTH];
   logic [COLOR_W-1:0] rd_ff;
   logic vld_ff, vld_in;
   logic [1:0] sel_ff;

   always_comb begin
      if (ctl_in.use_div) begin
         idx_in = (div_in.q > ctl_in.last) ? ctl_in.last : div_in.q;
      end else begin
         idx_in = ctl_in.idx;
      end
   end

   assign addr   = (c_ff.op == OP_LOAD) ? IDX_W'(c_ff.load_idx) : IDX_W'(idx_ff);
   assign vld_in = c_ff.vld && (c_ff.op == OP_RENDER);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff   <= '0;
         vld_ff <= 1'b0;
      end else if (adv) begin
         c_ff   <= ctl_in;
         vld_ff <= vld_in;
      end
      if (adv) begin
         idx_ff <= idx_in;
         sel_ff <= c_ff.sel;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && c_ff.vld && c_ff.op == OP_LOAD && c_ff.wr_ok) begin
         mem[addr] <= c_ff.load_rgb;
      end
      if (adv) begin
         rd_ff <= mem[addr];
      end
   end

   always_comb begin
      case (sel_ff)
         SEL_BG:  out_rgb = background_color;
         SEL_NAN: out_rgb = nan_color;
         default: out_rgb = rd_ff;
      endcase
   end

   assign out_valid = vld_ff;
endmodule

### design/clipped_colormap_pixel_render_top.sv
// Colormap pixel renderer: one item per clock while the result side is not stalling.
// Depends on cmap_pkg, cmap_front, cmap_div_stage, cmap_table and the assert header.
//
// Takes one item per clock when the result side is not stalling. A render item's
// result passes through 18 register stages, the input register being the first;
// a load item writes its table entry at the same point in the pipe and gives no
// result, so loads and renders act in the order they were accepted. The pipe is:
// input register, classify/clip, a 32x12 multiply, numerator build, twelve
// divider stages (one quotient bit each, so the index is exact with round half
// up), index select, and the registered table read. The whole pipe holds while
// a result waits on rsp_stall; req_stall is high only then. Table entries are
// undefined until loaded. The user must take care that configuration writes are
// made only while no item is in flight; the block itself does not enforce it.
`include "clipped_colormap_pixel_render_top_assert.svh"
module clipped_colormap_pixel_render_top import cmap_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  logic [LAST_W-1:0]        req_entry_index,
   input  logic [7:0]               req_entry_red,
   input  logic [7:0]               req_entry_green,
   input  logic [7:0]               req_entry_blue,
   input  logic signed [DATA_W-1:0] req_pixel_value,
   input  logic                     req_pixel_invalid,
   input  logic                     req_in_bounds,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_red,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_blue,
   input  logic                     csr_write,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [DATA_W-1:0]        csr_data
);
   logic signed [DATA_W-1:0] low_ff, high_ff;
   logic [LAST_W-1:0]  last_ff;
   logic [COLOR_W-1:0] nan_ff, bg_ff, rgb;
   logic adv;

   // divider chain: index 0 is the front end output
   ctl_type ctl_d [LAST_W+1];
   div_type div_d [LAST_W+1];

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= DATA_W'(255);
         last_ff <= LAST_W'(255);
         nan_ff  <= 24'hFF0000;
         bg_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOW:  low_ff  <= csr_data;
            CSR_HIGH: high_ff <= csr_data;
            CSR_LAST: last_ff <= csr_data[LAST_W-1:0];
            CSR_NAN:  nan_ff  <= csr_data[COLOR_W-1:0];
            CSR_BG:   bg_ff   <= csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipe moves unless a result sits stalled at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   cmap_front u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .req_valid(req_valid), .req_opcode(req_opcode),
      .req_entry_index(req_entry_index), .req_entry_red(req_entry_red),
      .req_entry_green(req_entry_green), .req_entry_blue(req_entry_blue),
      .req_pixel_value(req_pixel_value), .req_pixel_invalid(req_pixel_invalid),
      .req_in_bounds(req_in_bounds),
      .low_limit(low_ff), .high_limit(high_ff), .last_index(last_ff),
      .ctl_out(ctl_d[0]), .div_out(div_d[0])
   );

   for (genvar g = 0; g < LAST_W; g++) begin : g_div
      cmap_div_stage u_div (
         .clock(clock), .reset(reset), .adv(adv),
         .ctl_in(ctl_d[g]), .div_in(div_d[g]),
         .ctl_out(ctl_d[g+1]), .div_out(div_d[g+1])
      );
   end

   cmap_table u_table (
      .clock(clock), .reset(reset), .adv(adv),
      .ctl_in(ctl_d[LAST_W]), .div_in(div_d[LAST_W]),
      .nan_color(nan_ff), .background_color(bg_ff),
      .out_valid(rsp_valid), .out_rgb(rgb)
   );

   assign rsp_out_red   = rgb[23:16];
   assign rsp_out_green = rgb[15:8];
   assign rsp_out_blue  = rgb[7:0];

   `CMAP_ASSERT_ALWAYS(a_rst_no_rsp, reset |=> !rsp_valid, "result valid right after reset")
   `CMAP_ASSERT(a_q_in_range, ctl_d[LAST_W].vld && ctl_d[LAST_W].use_div |-> div_d[LAST_W].q <= ctl_d[LAST_W].last, "quotient beyond last entry")
   `CMAP_ASSERT(a_hold_front, !adv |=> $stable(ctl_d[0]), "front end moved while pipe held")
endmodule

### verif/clipped_colormap_pixel_render_top_tb.sv
// Self-checking bench for the colormap pixel renderer: directed and random
// load/render items, colors predicted in-bench. Depends on cmap_pkg and the top.
module clipped_colormap_pixel_render_top_tb;
   import cmap_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_opcode = OP_LOAD;
   logic [LAST_W-1:0]        req_entry_index = '0;
   logic [7:0]               req_entry_red = '0;
   logic [7:0]               req_entry_green = '0;
   logic [7:0]               req_entry_blue = '0;
   logic signed [DATA_W-1:0] req_pixel_value = '0;
   logic                     req_pixel_invalid = 1'b0;
   logic                     req_in_bounds = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_out_red;
   logic [7:0]               rsp_out_green;
   logic [7:0]               rsp_out_blue;
   logic                     csr_write = 1'b0;
   logic [CSR_W-1:0]         csr_index = CSR_LOW;
   logic [DATA_W-1:0]        csr_data = '0;

   // pipe is 18 deep; settle time before csr writes and at the end
   localparam int SETTLE = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   clipped_colormap_pixel_render_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the block state
   logic signed [DATA_W-1:0] low_lim, high_lim;
   logic [LAST_W-1:0]        last_idx;
   logic [COLOR_W-1:0]       nan_rgb, bg_rgb;
   logic [COLOR_W-1:0]       palette [TABLE_DEPTH];
   bit                       loaded [TABLE_DEPTH];
   logic [COLOR_W-1:0]       color_queue [$];

   int errors = 0, pixels_sent = 0, loads_sent = 0, colors_seen = 0, idle_cycles = 0;
   int rsp_wait = 0;

   task automatic report(input string msg);
      $display("MISMATCH %s at %0t", msg, $realtime);
      errors++;
   endtask

   function automatic logic [LAST_W-1:0] clip_index(input logic signed [DATA_W-1:0] v);
      longint lo, hi, span, off, q;
      lo = low_lim;
      hi = high_lim;
      if (longint'(v) <= lo) return '0;
      if (longint'(v) >= hi) return last_idx;
      span = hi - lo;
      off = longint'(v) - lo;
      q = (2 * off * longint'(last_idx) + span) / (2 * span);
      if (q > last_idx) q = last_idx;
      return q[LAST_W-1:0];
   endfunction

   // one item, holding valid steady across back-to-back sends
   task automatic send_item(input logic op, input logic [LAST_W-1:0] ei,
                            input logic [COLOR_W-1:0] rgb,
                            input logic signed [DATA_W-1:0] pv,
                            input logic inv, input logic inb, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 9) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_entry_index <= ei;
      {req_entry_red, req_entry_green, req_entry_blue} <= rgb;
      req_pixel_value <= pv;
      req_pixel_invalid <= inv;
      req_in_bounds <= inb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: predict now
      if (op == OP_LOAD) begin
         palette[ei] = rgb;
         loaded[ei] = 1'b1;
         loads_sent++;
      end else begin
         if (!inb) color_queue.push_back(bg_rgb);
         else if (inv) color_queue.push_back(nan_rgb);
         else color_queue.push_back(palette[clip_index(pv)]);
         pixels_sent++;
      end
   endtask

   // render one pixel; a table pick always lands on a loaded entry
   task automatic render(input logic signed [DATA_W-1:0] pv, input logic inv,
                         input logic inb, input bit gaps);
      logic [LAST_W-1:0] idx;
      idx = clip_index(pv);
      if (inb && !inv && !loaded[idx])
         send_item(OP_LOAD, idx, COLOR_W'($urandom), pv, 1'b0, 1'b1, gaps);
      send_item(OP_RENDER, LAST_W'($urandom), COLOR_W'($urandom), pv, inv, inb, gaps);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (color_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LOW:  low_lim = val;
         CSR_HIGH: high_lim = val;
         CSR_LAST: last_idx = val[LAST_W-1:0];
         CSR_NAN:  nan_rgb = val[COLOR_W-1:0];
         CSR_BG:   bg_rgb = val[COLOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_range(input int hi_entry, input bit gaps);
      for (int i = 0; i <= hi_entry; i++)
         send_item(OP_LOAD, LAST_W'(i), COLOR_W'($urandom), DATA_W'($urandom),
                   1'($urandom), 1'($urandom), gaps);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return low_lim;
         1: return high_lim;
         2: return low_lim + 1;
         3: return high_lim - 1;
         4: return DATA_W'($urandom);
         default: return DATA_W'((longint'(low_lim) + longint'(high_lim)) / 2
                                 + longint'($urandom_range(0, 64)) - 32);
      endcase
   endfunction

   task automatic random_pixel(input bit gaps);
      int kind;
      kind = $urandom_range(0, 9);
      render(pick_value(), kind == 0, kind != 1, gaps);
   endtask

   // ---- tests ----
   task automatic test_defaults();
      // reset config: 0..255 over 256 entries
      load_range(15, 1'b0);
      render(32'sh8000_0000, 1'b0, 1'b1, 1'b0);
      render(32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b0);
      render(0, 1'b0, 1'b1, 1'b0);
      render(255, 1'b0, 1'b1, 1'b0);
      render(128, 1'b0, 1'b1, 1'b0);
      render(5, 1'b1, 1'b1, 1'b0);  // NaN color
      render(5, 1'b1, 1'b0, 1'b0);  // out of bounds beats invalid
      render(5, 1'b0, 1'b0, 1'b0);
      go_idle();
   endtask

   task automatic test_full_table();
      // biggest table, extreme limits, all bits of every field toggled
      write_csr(CSR_LOW, 32'h8000_0000);
      write_csr(CSR_HIGH, 32'h7FFF_FFFF);
      write_csr(CSR_LAST, 32'hFFF);
      write_csr(CSR_NAN, 32'hFF_FFFF);
      write_csr(CSR_BG, 32'hFF_FFFF);
      send_item(OP_LOAD, 12'hFFF, 24'hFFFFFF, 0, 1'b0, 1'b0, 1'b0);
      send_item(OP_LOAD, 12'h000, 24'h000000, 0, 1'b0, 1'b0, 1'b0);
      send_item(OP_LOAD, 12'hAAA, 24'hA5A5A5, 0, 1'b0, 1'b0, 1'b0);
      send_item(OP_LOAD, 12'h555, 24'h5A5A5A, 0, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < 40; i++) random_pixel(1'b1);
      render(32'sh7FFF_FFFE, 1'b0, 1'b1, 1'b0);
      render(32'sh8000_0001, 1'b0, 1'b1, 1'b0);
      render(0, 1'b1, 1'b1, 1'b0);
      render(0, 1'b0, 1'b0, 1'b0);
      go_idle();
   endtask

   task automatic test_degenerate_limits();
      // high not above low: anything above low takes last entry
      write_csr(CSR_LOW, 32'd100);
      write_csr(CSR_HIGH, 32'hFFFF_FF00);
      write_csr(CSR_LAST, 32'd7);
      for (int i = 0; i < 20; i++) random_pixel(1'b1);
      go_idle();
      write_csr(CSR_HIGH, 32'd100);
      write_csr(CSR_LAST, 32'd0);
      for (int i = 0; i < 15; i++) random_pixel(1'b1);
      go_idle();
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CSR_LOW, $urandom);
         write_csr(CSR_HIGH, $urandom);
         if (phase[0]) write_csr(CSR_LOW, -$signed($urandom_range(0, 1000)));
         if (phase[0]) write_csr(CSR_HIGH, $urandom_range(0, 1000));
         write_csr(CSR_LAST, phase == 3 ? 32'd1 : $urandom_range(1, 4095));
         write_csr(CSR_NAN, $urandom);
         write_csr(CSR_BG, $urandom);
         for (int i = 0; i < 55; i++) begin
            // rewrite or add an entry now and then
            if ($urandom_range(0, 4) == 0)
               send_item(OP_LOAD, LAST_W'($urandom), COLOR_W'($urandom), DATA_W'($urandom),
                         1'($urandom), 1'($urandom), 1'b1);
            else
               random_pixel(phase != 2);  // phase 2 streams back to back
         end
         go_idle();  // sender holds off until drained
      end
   endtask

   // checker; after each result the result side may draw a random stall, with bursts of none
   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (color_queue.size() == 0) begin
            report("unexpected color");
         end else begin
            want = color_queue.pop_front();
            if (rsp_out_red !== want[23:16])
               report($sformatf("red got %02h want %02h", rsp_out_red, want[23:16]));
            if (rsp_out_green !== want[15:8])
               report($sformatf("green got %02h want %02h", rsp_out_green, want[15:8]));
            if (rsp_out_blue !== want[7:0])
               report($sformatf("blue got %02h want %02h", rsp_out_blue, want[7:0]));
         end
         colors_seen++;
         w = (colors_seen % 50 < 15) ? 0 : $urandom_range(0, 9);
         rsp_wait <= w;
         rsp_stall <= (w != 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("clipped_colormap_pixel_render_top_tb: errors");
         $finish;
      end
   end

   initial begin
      low_lim = 0;
      high_lim = 255;
      last_idx = 255;
      nan_rgb = 24'hFF0000;
      bg_rgb = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_full_table();
      test_degenerate_limits();
      test_random_mix();
      if (color_queue.size() != 0)
         report($sformatf("%0d colors never arrived", color_queue.size()));
      $display("Rendered %0d pixels and loaded %0d entries over default, full-range,",
               pixels_sent, loads_sent);
      $display("degenerate-limit and random settings; %0d colors checked", colors_seen);
      if (errors == 0) $display("clipped_colormap_pixel_render_top_tb: clean");
      else $display("clipped_colormap_pixel_render_top_tb: errors");
      $finish;
   end
endmodule
